@@ rtl/core/rcbp_pkg.sv @@
// rcbp_pkg: shared types and constants for the remote command byte parser
// used by rcbp_csr, rcbp_core and the top level; depends on nothing
package rcbp_pkg;

   localparam int FRAME_BYTES = 50;
   localparam int FRAME_POS_W = $clog2(FRAME_BYTES + 1);

   localparam int CSR_ADDR_W = 4;

   // register indexes on the csr port
   localparam logic [1:0] REG_SPEED_STEP = 2'd0;
   localparam logic [1:0] REG_SPEED_MIN  = 2'd1;
   localparam logic [1:0] REG_SPEED_MAX  = 2'd2;

   localparam logic [15:0] SPEED_STEP_RST = 16'd50;
   localparam logic [15:0] SPEED_MIN_RST  = 16'd0;
   localparam logic [15:0] SPEED_MAX_RST  = 16'd5000;

   // command bytes
   localparam logic [7:0] BYTE_DIR_FIRST = 8'h41;
   localparam logic [7:0] BYTE_DIR_LAST  = 8'h48;
   localparam logic [7:0] BYTE_DIR_STOP  = 8'h5A;
   localparam logic [7:0] BYTE_DIR_RAW   = 8'd10;
   localparam logic [7:0] BYTE_SLOWER    = 8'h59;
   localparam logic [7:0] BYTE_FASTER    = 8'h58;
   localparam logic [7:0] BYTE_OPEN      = 8'h7B;
   localparam logic [7:0] BYTE_CLOSE     = 8'h7D;
   localparam logic [7:0] BYTE_REPORT    = 8'h50;
   localparam logic [7:0] ID_NONE        = 8'h23;
   localparam logic [7:0] ID_GAIN_P      = 8'h30;
   localparam logic [7:0] ID_GAIN_I      = 8'h31;
   localparam logic [7:0] ID_SPEED       = 8'h32;
   localparam logic [7:0] ASCII_ZERO     = 8'h30;

   typedef struct packed {
      logic        [15:0] speed_step;
      logic signed [15:0] speed_min;
      logic signed [15:0] speed_max;
   } cfg_type;

   typedef struct packed {
      logic        [3:0]  direction;
      logic signed [31:0] speed;
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic               report_request;
      logic               frame_closed;
   } result_type;

endpackage

@@ rtl/core/rcbp_csr.sv @@
// rcbp_csr: apb-style register file for speed step and speed clamps
// depends on rcbp_pkg
module rcbp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rcbp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output rcbp_pkg::cfg_type               cfg
);
   import rcbp_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SPEED_STEP: cfg_in.speed_step = pwdata[15:0];
            REG_SPEED_MIN:  cfg_in.speed_min  = signed'(pwdata[15:0]);
            REG_SPEED_MAX:  cfg_in.speed_max  = signed'(pwdata[15:0]);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_step <= SPEED_STEP_RST;
         cfg_ff.speed_min  <= signed'(SPEED_MIN_RST);
         cfg_ff.speed_max  <= signed'(SPEED_MAX_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SPEED_STEP: prdata = {16'd0, cfg_ff.speed_step};
         REG_SPEED_MIN:  prdata = 32'(cfg_ff.speed_min);
         REG_SPEED_MAX:  prdata = 32'(cfg_ff.speed_max);
         default:        prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

@@ rtl/core/rcbp_core.sv @@
// rcbp_core: parser state and the per-byte update (direction, speed, frames)
// depends on rcbp_pkg
module rcbp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  rcbp_pkg::cfg_type      cfg,
   output rcbp_pkg::result_type   result
);
   import rcbp_pkg::*;

   logic        [3:0]             dir_ff, dir_in;
   logic signed [31:0]            speed_ff, speed_in;
   logic signed [31:0]            gain_p_ff, gain_p_in;
   logic signed [31:0]            gain_i_ff, gain_i_in;
   logic                          in_frame_ff, in_frame_in;
   logic        [FRAME_POS_W-1:0] pos_ff, pos_in;
   logic        [7:0]             id_ff, id_in;
   logic        [7:0]             byte3_ff, byte3_in;
   logic signed [31:0]            acc_ff, acc_in;

   logic signed [33:0] speed_dn;
   logic signed [33:0] speed_up;
   logic signed [36:0] acc_wide;
   logic signed [36:0] acc_sum;
   logic signed [9:0]  digit;
   logic signed [31:0] acc_sat;
   logic               frame_open;
   logic               store;
   logic               report;
   logic               closed;

   localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
   localparam logic signed [36:0] SAT_LO = -37'sd2147483648;

   assign speed_dn = 34'(speed_ff) - signed'({18'd0, cfg.speed_step});
   assign speed_up = 34'(speed_ff) + signed'({18'd0, cfg.speed_step});

   // times ten as two shifts, then the digit
   assign acc_wide = 37'(acc_ff);
   assign digit    = signed'({2'b00, rx_byte}) - signed'({2'b00, ASCII_ZERO});
   assign acc_sum  = (acc_wide <<< 3) + (acc_wide <<< 1) + 37'(digit);
   assign acc_sat  = (acc_sum > SAT_HI) ? 32'sh7FFFFFFF :
                     (acc_sum < SAT_LO) ? 32'sh80000000 : acc_sum[31:0];

   assign frame_open = in_frame_ff || (rx_byte == BYTE_OPEN);
   assign store      = (rx_byte != BYTE_CLOSE) && frame_open &&
                       (pos_ff < FRAME_POS_W'(FRAME_BYTES));

   always_comb begin
      dir_in      = dir_ff;
      speed_in    = speed_ff;
      gain_p_in   = gain_p_ff;
      gain_i_in   = gain_i_ff;
      in_frame_in = frame_open;
      pos_in      = pos_ff;
      id_in       = id_ff;
      byte3_in    = byte3_ff;
      acc_in      = acc_ff;
      report      = 1'b0;
      closed      = 1'b0;

      if (rx_byte inside {[BYTE_DIR_FIRST:BYTE_DIR_LAST]}) begin
         dir_in = rx_byte[3:0];
      end else if (rx_byte == BYTE_DIR_STOP) begin
         dir_in = 4'd0;
      end else if (rx_byte <= BYTE_DIR_RAW) begin
         dir_in = rx_byte[3:0];
      end else if (rx_byte == BYTE_SLOWER) begin
         // lower clamp keeps the result in range
         speed_in = (speed_dn < 34'(cfg.speed_min)) ? 32'(cfg.speed_min) : speed_dn[31:0];
      end else if (rx_byte == BYTE_FASTER) begin
         speed_in = (speed_up > 34'(cfg.speed_max)) ? 32'(cfg.speed_max) : speed_up[31:0];
      end

      if (rx_byte == BYTE_CLOSE) begin
         if (in_frame_ff) begin
            closed = 1'b1;
            if (byte3_ff == BYTE_REPORT) begin
               report = 1'b1;
            end else if (id_ff != ID_NONE) begin
               case (id_ff)
                  ID_GAIN_P: gain_p_in = acc_ff;
                  ID_GAIN_I: gain_i_in = acc_ff;
                  ID_SPEED:  speed_in  = acc_ff;
                  default:   gain_p_in = gain_p_ff;
               endcase
            end
         end
         in_frame_in = 1'b0;
         pos_in      = '0;
         id_in       = 8'd0;
         byte3_in    = 8'd0;
         acc_in      = 32'sd0;
      end else if (store) begin
         if (pos_ff == FRAME_POS_W'(1)) id_in = rx_byte;
         if (pos_ff == FRAME_POS_W'(3)) byte3_in = rx_byte;
         if (pos_ff >= FRAME_POS_W'(3)) acc_in = acc_sat;
         pos_in = pos_ff + FRAME_POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff      <= 4'd0;
         speed_ff    <= 32'sd0;
         gain_p_ff   <= 32'sd0;
         gain_i_ff   <= 32'sd0;
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         id_ff       <= 8'd0;
         byte3_ff    <= 8'd0;
         acc_ff      <= 32'sd0;
      end else if (step) begin
         dir_ff      <= dir_in;
         speed_ff    <= speed_in;
         gain_p_ff   <= gain_p_in;
         gain_i_ff   <= gain_i_in;
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         id_ff       <= id_in;
         byte3_ff    <= byte3_in;
         acc_ff      <= acc_in;
      end
   end

   assign result.direction      = dir_in;
   assign result.speed          = speed_in;
   assign result.gain_p         = gain_p_in;
   assign result.gain_i         = gain_i_in;
   assign result.report_request = report;
   assign result.frame_closed   = closed;
endmodule

@@ rtl/core/remote_command_byte_parser.sv @@
// remote_command_byte_parser: top level with input stage, result stage and csr port
// depends on rcbp_pkg, rcbp_csr and rcbp_core
//
// Takes one received byte per beat and returns one result beat per byte with the
// direction, speed setpoint, both gains and the frame close / report pulses after
// that byte. Sustained rate is one byte per clock while rsp_ready stays high; an
// accepted byte reaches the result register through an input register and one
// state update stage whose longest path is the times-ten saturating accumulate.
// req_ready only drops when both the input register and the result register are
// full and rsp_ready is low. Registers: speed_step at 0x0, speed_min at 0x4,
// speed_max at 0x8; write them only while no beat is in flight.
module remote_command_byte_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [3:0]                      rsp_direction,
   output logic signed [31:0]              rsp_speed,
   output logic signed [31:0]              rsp_gain_p,
   output logic signed [31:0]              rsp_gain_i,
   output logic                            rsp_report_request,
   output logic                            rsp_frame_closed,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rcbp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import rcbp_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   rcbp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rcbp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_direction      = rsp_ff.direction;
   assign rsp_speed          = rsp_ff.speed;
   assign rsp_gain_p         = rsp_ff.gain_p;
   assign rsp_gain_i         = rsp_ff.gain_i;
   assign rsp_report_request = rsp_ff.report_request;
   assign rsp_frame_closed   = rsp_ff.frame_closed;
endmodule

@@ rtl/core/rcbp_checker.sv @@
// rcbp_checker: port-level assertions for remote_command_byte_parser
// needs only the top level's ports; bound to the top level at the end of this file
module rcbp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [3:0]         rsp_direction,
   input logic signed [31:0] rsp_speed,
   input logic               rsp_report_request,
   input logic               rsp_frame_closed
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed) &&
      $stable(rsp_direction) && $stable(rsp_frame_closed))
      else $error("result beat changed while stalled");

   a_report_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_request |-> rsp_frame_closed)
      else $error("report request without frame close");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_direction <= 4'd10)
      else $error("direction code out of range");

   // with the result register empty the input side never stalls
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");
endmodule

bind remote_command_byte_parser rcbp_checker u_rcbp_checker (.*);

@@ dv/tb.sv @@
// tb: self-checking bench for remote_command_byte_parser, random and table-driven bytes
// checks every beat against an in-bench parser model or a typed row; needs rcbp_pkg and the rtl
module tb;
   import rcbp_pkg::*;

   localparam int RSP_HOLD_CYCLES = 60;
   localparam int STALL_LIMIT     = 2000;
   localparam int PHASE_BYTES     = 130;
   localparam int NUM_PHASES      = 6;
   localparam longint INT32_HI    = 64'sd2147483647;
   localparam longint INT32_LO    = -64'sd2147483648;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_rx_byte = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic [3:0]             rsp_direction;
   logic signed [31:0]     rsp_speed;
   logic signed [31:0]     rsp_gain_p;
   logic signed [31:0]     rsp_gain_i;
   logic                   rsp_report_request;
   logic                   rsp_frame_closed;
   logic                   psel        = 1'b0;
   logic                   penable     = 1'b0;
   logic                   pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr       = '0;
   logic [31:0]            pwdata      = 32'd0;
   logic [31:0]            prdata;
   logic                   pready;

   remote_command_byte_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_direction      (rsp_direction),
      .rsp_speed          (rsp_speed),
      .rsp_gain_p         (rsp_gain_p),
      .rsp_gain_i         (rsp_gain_i),
      .rsp_report_request (rsp_report_request),
      .rsp_frame_closed   (rsp_frame_closed),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // parser model state, mirrors the block after each accepted byte
   cfg_type            setting = '{SPEED_STEP_RST, SPEED_MIN_RST, SPEED_MAX_RST};
   logic [3:0]         dir_now    = 4'd0;
   logic signed [31:0] speed_now  = 32'sd0;
   logic signed [31:0] gain_p_now = 32'sd0;
   logic signed [31:0] gain_i_now = 32'sd0;
   logic signed [31:0] acc_now    = 32'sd0;
   bit                 frame_open = 1'b0;
   int                 frame_count = 0;
   logic [7:0]         frame_id   = 8'd0;
   logic [7:0]         frame_b3   = 8'd0;

   result_type expected_setpoints[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_rsp      = 1'b0;
   int  errors        = 0;
   int  bytes_sent    = 0;
   int  beats_checked = 0;
   int  frames_closed = 0;
   int  reports_seen  = 0;

   typedef struct {
      logic [7:0] rx;
      bit         typed;
      logic [3:0] dir;
      int         speed;
      int         gain_p;
      int         gain_i;
      bit         report;
      bit         closed;
   } stim_row_type;

   // rows marked typed carry the expected beat; the model advances on every row and predicts the rest
   stim_row_type stim_table [28] = '{
      '{8'h00,          1, 0,  0,  0,  0, 0, 0},
      '{BYTE_DIR_RAW,   1, 10, 0,  0,  0, 0, 0},
      '{BYTE_DIR_LAST,  1, 8,  0,  0,  0, 0, 0},
      '{BYTE_DIR_FIRST, 1, 1,  0,  0,  0, 0, 0},
      '{BYTE_DIR_STOP,  1, 0,  0,  0,  0, 0, 0},
      '{BYTE_FASTER,    1, 0,  50, 0,  0, 0, 0},
      '{BYTE_SLOWER,    1, 0,  0,  0,  0, 0, 0},
      '{BYTE_SLOWER,    1, 0,  0,  0,  0, 0, 0},
      '{BYTE_CLOSE,     1, 0,  0,  0,  0, 0, 0},
      '{BYTE_OPEN,      0, 0,  0,  0,  0, 0, 0},
      '{ID_GAIN_P,      0, 0,  0,  0,  0, 0, 0},
      '{8'h78,          0, 0,  0,  0,  0, 0, 0},
      '{8'h31,          0, 0,  0,  0,  0, 0, 0},
      '{8'h32,          0, 0,  0,  0,  0, 0, 0},
      '{BYTE_CLOSE,     1, 0,  0,  12, 0, 0, 1},
      '{BYTE_OPEN,      0, 0,  0,  0,  0, 0, 0},
      '{ID_NONE,        0, 0,  0,  0,  0, 0, 0},
      '{8'h2C,          0, 0,  0,  0,  0, 0, 0},
      '{BYTE_REPORT,    0, 0,  0,  0,  0, 0, 0},
      '{BYTE_CLOSE,     1, 0,  0,  12, 0, 1, 1},
      '{BYTE_OPEN,      0, 0,  0,  0,  0, 0, 0},
      '{BYTE_OPEN,      0, 0,  0,  0,  0, 0, 0},
      '{BYTE_CLOSE,     1, 0,  0,  12, 0, 0, 1},
      '{BYTE_FASTER,    1, 0,  50, 12, 0, 0, 0},
      '{BYTE_OPEN,      0, 0,  0,  0,  0, 0, 0},
      '{ID_SPEED,       0, 0,  0,  0,  0, 0, 0},
      '{BYTE_CLOSE,     1, 0,  0,  12, 0, 0, 1},
      '{8'hFF,          0, 0,  0,  0,  0, 0, 0}
   };

   function automatic logic signed [31:0] clamp_to_int32(input longint v);
      if (v > INT32_HI) return 32'(INT32_HI);
      if (v < INT32_LO) return 32'(INT32_LO);
      return 32'(v);
   endfunction

   // advances the parser model by one byte and returns the beat it should produce
   function automatic result_type parse_byte(input logic [7:0] b);
      result_type r;
      longint     t;
      r = '0;
      if (b >= BYTE_DIR_FIRST && b <= BYTE_DIR_LAST) dir_now = 4'(b - BYTE_DIR_FIRST + 8'd1);
      else if (b == BYTE_DIR_STOP) dir_now = 4'd0;
      else if (b <= BYTE_DIR_RAW) dir_now = b[3:0];
      else if (b == BYTE_SLOWER) begin
         t = longint'(speed_now) - longint'(setting.speed_step);
         if (t < longint'($signed(setting.speed_min))) t = longint'($signed(setting.speed_min));
         speed_now = clamp_to_int32(t);
      end else if (b == BYTE_FASTER) begin
         t = longint'(speed_now) + longint'(setting.speed_step);
         if (t > longint'($signed(setting.speed_max))) t = longint'($signed(setting.speed_max));
         speed_now = clamp_to_int32(t);
      end

      if (b == BYTE_OPEN) frame_open = 1'b1;

      if (b == BYTE_CLOSE) begin
         if (frame_open) begin
            r.frame_closed = 1'b1;
            if (frame_b3 == BYTE_REPORT) r.report_request = 1'b1;
            else if (frame_id != ID_NONE) begin
               if (frame_id == ID_GAIN_P) gain_p_now = acc_now;
               else if (frame_id == ID_GAIN_I) gain_i_now = acc_now;
               else if (frame_id == ID_SPEED) speed_now = acc_now;
            end
         end
         frame_open  = 1'b0;
         frame_count = 0;
         frame_id    = 8'd0;
         frame_b3    = 8'd0;
         acc_now     = 32'sd0;
      end else if (frame_open && frame_count < FRAME_BYTES) begin
         if (frame_count == 1) frame_id = b;
         if (frame_count == 3) frame_b3 = b;
         if (frame_count >= 3)
            acc_now = clamp_to_int32(longint'(acc_now) * 10 + longint'(b) - longint'(ASCII_ZERO));
         frame_count++;
      end

      r.direction = dir_now;
      r.speed     = speed_now;
      r.gain_p    = gain_p_now;
      r.gain_i    = gain_i_now;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input result_type want = '0);
      result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predicted = parse_byte(b);
      if (typed) predicted = want;
      expected_setpoints.push_back(predicted);
      bytes_sent++;
      if (predicted.frame_closed) frames_closed++;
      if (predicted.report_request) reports_seen++;
   endtask

   function automatic logic [7:0] any_but_close();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == BYTE_CLOSE) b = BYTE_OPEN;
      return b;
   endfunction

   function automatic logic [7:0] digit();
      return 8'(ASCII_ZERO + $urandom_range(9));
   endfunction

   task automatic send_frame();
      int         shape;
      int         n;
      logic [7:0] id;
      shape = $urandom_range(99);
      case ($urandom_range(4))
         0: id = ID_GAIN_P;
         1: id = ID_GAIN_I;
         2: id = ID_SPEED;
         3: id = ID_NONE;
         default: id = any_but_close();
      endcase
      send_byte(BYTE_OPEN);
      // a few frames stop after the open or the id to cover short frames
      if (shape >= 5) begin
         send_byte(id);
         if (shape >= 10) begin
            send_byte(any_but_close());
            if (shape < 22) begin
               send_byte(BYTE_REPORT);
               repeat ($urandom_range(3)) send_byte(digit());
            end else if (shape < 32) begin
               repeat ($urandom_range(8, 13)) send_byte(8'hFF);
            end else if (shape < 40) begin
               // bytes below '0' pull the value negative
               repeat ($urandom_range(9, 13)) send_byte(8'($urandom_range(8'h0B, 8'h2F)));
            end else if (shape < 45) begin
               // zeros nearly up to the frame limit, then digits; those past the limit must be dropped
               n = $urandom_range(44, 56);
               for (int i = 0; i < n; i++) send_byte(i < 44 ? ASCII_ZERO : digit());
            end else begin
               n = $urandom_range(1, 10);
               for (int i = 0; i < n; i++)
                  send_byte($urandom_range(9) == 0 ? any_but_close() : digit());
            end
         end
      end
      if ($urandom_range(19) != 0) send_byte(BYTE_CLOSE);
   endtask

   task automatic send_command();
      logic [7:0] b;
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(5))
            0: b = 8'($urandom_range(BYTE_DIR_FIRST, BYTE_DIR_LAST));
            1: b = BYTE_DIR_STOP;
            2: b = 8'($urandom_range(BYTE_DIR_RAW));
            3: b = BYTE_SLOWER;
            default: b = BYTE_FASTER;
         endcase
         send_byte(b);
      end
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (expected_setpoints.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_SPEED_STEP: setting.speed_step = value;
         REG_SPEED_MIN:  setting.speed_min  = value;
         REG_SPEED_MAX:  setting.speed_max  = value;
         default: ;
      endcase
   endtask

   task automatic write_setting(input logic [15:0] step, input logic [15:0] lo,
                                input logic [15:0] hi);
      write_reg(REG_SPEED_STEP, step);
      write_reg(REG_SPEED_MIN, lo);
      write_reg(REG_SPEED_MAX, hi);
   endtask

   // receiver: random stalls, plus one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_setpoints.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = expected_setpoints.pop_front();
            if (rsp_direction !== want.direction)
               report_mismatch($sformatf("beat %0d direction %0d, expected %0d",
                  beats_checked, rsp_direction, want.direction));
            if (rsp_speed !== want.speed)
               report_mismatch($sformatf("beat %0d speed %0d, expected %0d",
                  beats_checked, rsp_speed, want.speed));
            if (rsp_gain_p !== want.gain_p)
               report_mismatch($sformatf("beat %0d gain_p %0d, expected %0d",
                  beats_checked, rsp_gain_p, want.gain_p));
            if (rsp_gain_i !== want.gain_i)
               report_mismatch($sformatf("beat %0d gain_i %0d, expected %0d",
                  beats_checked, rsp_gain_i, want.gain_i));
            if (rsp_report_request !== want.report_request)
               report_mismatch($sformatf("beat %0d report_request %b, expected %b",
                  beats_checked, rsp_report_request, want.report_request));
            if (rsp_frame_closed !== want.frame_closed)
               report_mismatch($sformatf("beat %0d frame_closed %b, expected %b",
                  beats_checked, rsp_frame_closed, want.frame_closed));
         end
         beats_checked++;
      end
   end

   // ends the run if neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      result_type want;
      int         target;
      int         pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 15;
      recv_idle_pct = 70;
      foreach (stim_table[i]) begin
         want                = '0;
         want.direction      = stim_table[i].dir;
         want.speed          = stim_table[i].speed;
         want.gain_p         = stim_table[i].gain_p;
         want.gain_i         = stim_table[i].gain_i;
         want.report_request = stim_table[i].report;
         want.frame_closed   = stim_table[i].closed;
         send_byte(stim_table[i].rx, stim_table[i].typed, want);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 15;
            recv_idle_pct = 70;
         end else if (phase < 4) begin
            send_idle_pct = 70;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase > 0) begin
            wait_all_results();
            case (phase)
               1: write_setting(16'hFFFF, 16'h8000, 16'h7FFF);
               2: write_setting(16'd0, 16'h7FFF, 16'h8000);
               3: write_setting(16'd1, -16'sd100, 16'sd100);
               4: write_setting(16'($urandom), 16'($urandom), 16'($urandom));
               default: write_setting(SPEED_STEP_RST, SPEED_MIN_RST, SPEED_MAX_RST);
            endcase
         end
         if (phase == 0 || phase == 4) hold_rsp = 1'b1;
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 50) send_frame();
            else if (pick < 80) send_command();
            else send_byte(8'($urandom_range(255)));
         end
      end

      wait_all_results();
      repeat (8) @(posedge clock);

      $display("Covered %0d bytes under %0d register settings, %0d result beats checked",
               bytes_sent, NUM_PHASES, beats_checked);
      $display("%0d frames closed, %0d report requests, %0d mismatches",
               frames_closed, reports_seen, errors);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
